### rtl/tsjd_pkg.sv
// Shared widths, result codes and register indexes of the temperature stability jump detector.
package tsjd_pkg;

    localparam int TEMP_W     = 15;
    localparam int DEV_W      = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_STAB = 2'd1,
        EV_JUMP = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        BEEP_NONE  = 2'd0,
        BEEP_SHORT = 2'd1,
        BEEP_ALERT = 2'd2
    } t_beep;

    localparam logic [CFG_IDX_W-1:0] REG_STAB_TOL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_EN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECENT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REGAIN   = 3'd6;

    localparam logic [8:0]  RST_STAB_TOL = 9'd10;
    localparam logic [9:0]  RST_JUMP_THR = 10'd20;
    localparam logic [21:0] RST_SETTLE   = 22'd600000;
    localparam logic [19:0] RST_RECENT   = 20'd30000;
    localparam logic [21:0] RST_COOLDOWN = 22'd60000;
    localparam logic [21:0] RST_REGAIN   = 22'd120000;

    localparam logic signed [TEMP_W-1:0] BASELINE_RST = -15'sd12700;

endpackage

### rtl/temperature_stability_jump_detector_top.sv
// Temperature stability and jump detector: ring history, sequential window scan, serial mean divider.
//
//  channel   direction  handshake                       payload
//  cfg       in         i_cfg_we                        i_cfg_idx, i_cfg_data
//  sample    in         i_in_valid / o_in_stall         i_sample_temp, i_sample_time_ms
//  result    out        o_out_valid / i_out_stall       o_event_res .. o_window_spread
//
// Each sample is scanned with one history read per cycle through the scan accumulator,
// then the mean is formed with one quotient bit per cycle by the serial divider.
// o_in_stall is high from accept until the result is loaded into the output register; a held
// result does not block the next sample, only a full output register holds the final step.
// Synchronous active-low reset; history contents are not cleared, a fill count bounds the scan.
module temperature_stability_jump_detector_top #(
    parameter int HISTORY_DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tsjd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tsjd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [tsjd_pkg::TEMP_W-1:0]   i_sample_temp,
    input  logic [tsjd_pkg::TIME_W-1:0]          i_sample_time_ms,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [1:0]                           o_event_res,
    output logic [1:0]                           o_beep,
    output logic                                 o_stable_now,
    output logic                                 o_locked,
    output logic signed [tsjd_pkg::TEMP_W-1:0]   o_baseline_temp,
    output logic signed [tsjd_pkg::DEV_W-1:0]    o_deviation,
    output logic signed [tsjd_pkg::TEMP_W-1:0]   o_window_mean,
    output logic [tsjd_pkg::TEMP_W-1:0]          o_window_spread
);
    import tsjd_pkg::*;

    localparam int AW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = TEMP_W + CNT_W;
    localparam int DCNT_W = $clog2(SUM_W + 1);

    localparam logic signed [TEMP_W-1:0] T_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
    localparam logic signed [TEMP_W-1:0] T_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DIV    = 4'b0100,
        S_DECIDE = 4'b1000
    } t_state;

    // history
    logic signed [TEMP_W-1:0] mem_temp [HISTORY_DEPTH];
    logic [TIME_W-1:0]        mem_time [HISTORY_DEPTH];

    // control
    t_state             r_state;
    logic [AW-1:0]      r_wslot;
    logic [CNT_W-1:0]   r_fill;
    logic [CNT_W-1:0]   r_rd_idx;
    logic               r_rd_pend;
    logic               r_out_valid;

    // configuration
    logic [8:0]         r_tol;
    logic [9:0]         r_thr;
    logic [21:0]        r_settle;
    logic               r_beep_en;
    logic [19:0]        r_recent;
    logic [21:0]        r_cool;
    logic [21:0]        r_regain;

    // detector state
    logic               r_locked;
    logic signed [TEMP_W-1:0] r_base;
    logic               r_alert_lat;
    logic [TIME_W-1:0]  r_last_alert;
    logic [TIME_W-1:0]  r_stable_since;

    // datapath
    logic signed [TEMP_W-1:0] r_temp;
    logic [TIME_W-1:0]        r_now;
    logic signed [TEMP_W-1:0] r_rd_temp;
    logic [TIME_W-1:0]        r_rd_time;
    logic signed [TEMP_W-1:0] r_wmin, r_wmax, r_rmin, r_rmax;
    logic signed [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]         r_cnt;
    logic [TIME_W-1:0]        r_oldest;
    logic [SUM_W-1:0]         r_dq;
    logic [CNT_W-1:0]         r_rem;
    logic                     r_neg;
    logic [DCNT_W-1:0]        r_dcnt;

    // output payload
    logic [1:0]               r_o_event;
    logic [1:0]               r_o_beep;
    logic                     r_o_stable;
    logic                     r_o_locked;
    logic signed [TEMP_W-1:0] r_o_base;
    logic signed [DEV_W-1:0]  r_o_dev;
    logic signed [TEMP_W-1:0] r_o_mean;
    logic [TEMP_W-1:0]        r_o_spread;

    logic in_acc, issue, scan_done, div_done, out_load;
    logic [TIME_W-1:0] age;
    logic in_set, in_rec;
    logic [SUM_W-1:0] sum_mag;
    logic [CNT_W:0]   trial;
    logic             q_bit;
    logic [CNT_W-1:0] n_rem;
    logic [SUM_W-1:0] mean_full;
    logic signed [TEMP_W-1:0] mean;
    logic signed [DEV_W-1:0]  spread16, rspread16, dev16;
    logic [DEV_W-1:0]         absd;
    logic stable, big, rs_big, cool_ok, regain;

    t_event                   n_event;
    t_beep                    n_beep;
    logic                     n_locked, n_alat;
    logic signed [TEMP_W-1:0] n_base;
    logic [TIME_W-1:0]        n_last, n_since;
    logic signed [DEV_W-1:0]  n_dev;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign issue      = (r_state == S_SCAN) && (r_rd_idx != r_fill);
    assign scan_done  = (r_state == S_SCAN) && (r_rd_idx == r_fill) && !r_rd_pend;
    assign div_done   = (r_state == S_DIV) && (r_dcnt == '0);
    assign out_load   = (r_state == S_DECIDE) && (!r_out_valid || !i_out_stall);

    // per-entry qualifiers
    assign age    = r_now - r_rd_time;
    assign in_set = age <= {10'd0, r_settle};
    assign in_rec = age <= {12'd0, r_recent};

    // restoring divider on the sum magnitude
    assign sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign trial   = {r_rem, r_dq[SUM_W-1]};
    assign q_bit   = trial >= {1'b0, r_cnt};
    assign n_rem   = q_bit ? CNT_W'(trial - {1'b0, r_cnt}) : trial[CNT_W-1:0];

    assign mean_full = r_neg ? (~r_dq + 1'b1) : r_dq;
    assign mean      = signed'(mean_full[TEMP_W-1:0]);

    // decision terms
    assign spread16  = DEV_W'(r_wmax) - DEV_W'(r_wmin);
    assign rspread16 = DEV_W'(r_rmax) - DEV_W'(r_rmin);
    assign dev16     = DEV_W'(r_temp) - DEV_W'(r_base);
    assign absd      = dev16[DEV_W-1] ? DEV_W'(-dev16) : DEV_W'(dev16);
    assign stable    = (unsigned'(spread16) <= {7'd0, r_tol}) &&
                       (r_oldest >= {11'd0, r_settle[21:1]});
    assign big       = absd >= {6'd0, r_thr};
    assign rs_big    = {unsigned'(rspread16), 1'b0} >= {7'd0, r_thr};
    assign cool_ok   = !r_alert_lat || ((r_now - r_last_alert) > {10'd0, r_cool});
    assign regain    = (r_now - r_stable_since) > {10'd0, r_regain};

    always_comb begin
        n_event  = EV_NONE;
        n_beep   = BEEP_NONE;
        n_locked = r_locked;
        n_base   = r_base;
        n_alat   = r_alert_lat;
        n_last   = r_last_alert;
        n_since  = r_stable_since;
        n_dev    = '0;
        if (!r_locked) begin
            if (stable) begin
                n_locked = 1'b1;
                n_base   = mean;
                n_alat   = 1'b0;
                n_since  = r_now;
                n_event  = EV_STAB;
                n_beep   = BEEP_SHORT;
            end
        end else begin
            n_dev = dev16;
            if (big) begin
                if (rs_big) begin
                    if (cool_ok) begin
                        n_event = EV_JUMP;
                        if (r_beep_en) begin
                            n_beep = BEEP_ALERT;
                        end
                        n_alat = 1'b1;
                        n_last = r_now;
                    end
                end else begin
                    // slow drift: follow the mean
                    n_base = mean;
                    n_alat = 1'b0;
                end
            end else begin
                n_alat = 1'b0;
            end
            if (!stable) begin
                if (regain) begin
                    n_base  = mean;
                    n_since = r_now;
                end
            end else begin
                n_since = r_now;
            end
        end
    end

    // control, configuration and detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_wslot        <= '0;
            r_fill         <= '0;
            r_rd_idx       <= '0;
            r_rd_pend      <= 1'b0;
            r_out_valid    <= 1'b0;
            r_tol          <= RST_STAB_TOL;
            r_thr          <= RST_JUMP_THR;
            r_settle       <= RST_SETTLE;
            r_beep_en      <= 1'b1;
            r_recent       <= RST_RECENT;
            r_cool         <= RST_COOLDOWN;
            r_regain       <= RST_REGAIN;
            r_locked       <= 1'b0;
            r_base         <= BASELINE_RST;
            r_alert_lat    <= 1'b0;
            r_last_alert   <= '0;
            r_stable_since <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_STAB_TOL: r_tol     <= i_cfg_data[8:0];
                    REG_JUMP_THR: r_thr     <= i_cfg_data[9:0];
                    REG_SETTLE:   r_settle  <= i_cfg_data[21:0];
                    REG_BEEP_EN:  r_beep_en <= i_cfg_data[0];
                    REG_RECENT:   r_recent  <= i_cfg_data[19:0];
                    REG_COOLDOWN: r_cool    <= i_cfg_data[21:0];
                    REG_REGAIN:   r_regain  <= i_cfg_data[21:0];
                    default: ;
                endcase
            end

            r_rd_pend <= issue;
            if (issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_wslot  <= (r_wslot == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wslot + 1'b1;
                        if (r_fill != CNT_W'(HISTORY_DEPTH)) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        r_rd_idx <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (out_load) begin
                        r_locked       <= n_locked;
                        r_base         <= n_base;
                        r_alert_lat    <= n_alat;
                        r_last_alert   <= n_last;
                        r_stable_since <= n_since;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // history memory: one write per sample, one registered read per scan cycle
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            mem_temp[r_wslot] <= i_sample_temp;
            mem_time[r_wslot] <= i_sample_time_ms;
        end
        if (issue) begin
            r_rd_temp <= mem_temp[r_rd_idx[AW-1:0]];
            r_rd_time <= mem_time[r_rd_idx[AW-1:0]];
        end
    end

    // scan accumulator, divider and output payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_temp   <= i_sample_temp;
            r_now    <= i_sample_time_ms;
            r_wmin   <= T_MAX;
            r_wmax   <= T_MIN;
            r_rmin   <= T_MAX;
            r_rmax   <= T_MIN;
            r_sum    <= '0;
            r_cnt    <= '0;
            r_oldest <= '0;
        end else if (r_rd_pend) begin
            if (in_set) begin
                if (r_rd_temp < r_wmin) r_wmin <= r_rd_temp;
                if (r_rd_temp > r_wmax) r_wmax <= r_rd_temp;
                r_sum <= r_sum + SUM_W'(r_rd_temp);
                r_cnt <= r_cnt + 1'b1;
                if (age > r_oldest) r_oldest <= age;
            end
            if (in_rec) begin
                if (r_rd_temp < r_rmin) r_rmin <= r_rd_temp;
                if (r_rd_temp > r_rmax) r_rmax <= r_rd_temp;
            end
        end

        if (scan_done) begin
            r_dq   <= sum_mag;
            r_rem  <= '0;
            r_neg  <= r_sum[SUM_W-1];
            r_dcnt <= DCNT_W'(SUM_W);
        end else if (r_state == S_DIV && r_dcnt != '0) begin
            r_dq   <= {r_dq[SUM_W-2:0], q_bit};
            r_rem  <= n_rem;
            r_dcnt <= r_dcnt - 1'b1;
        end

        if (out_load) begin
            r_o_event  <= n_event;
            r_o_beep   <= n_beep;
            r_o_stable <= stable;
            r_o_locked <= n_locked;
            r_o_base   <= n_base;
            r_o_dev    <= n_dev;
            r_o_mean   <= mean;
            r_o_spread <= spread16[TEMP_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_res     = r_o_event;
    assign o_beep          = r_o_beep;
    assign o_stable_now    = r_o_stable;
    assign o_locked        = r_o_locked;
    assign o_baseline_temp = r_o_base;
    assign o_deviation     = r_o_dev;
    assign o_window_mean   = r_o_mean;
    assign o_window_spread = r_o_spread;

endmodule

### rtl/tsjd_checker.sv
// Port-level checks of the temperature stability jump detector and their bind.
module tsjd_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [1:0]                          o_event_res,
    input logic [1:0]                          o_beep,
    input logic                                o_stable_now,
    input logic                                o_locked,
    input logic signed [tsjd_pkg::TEMP_W-1:0]  o_baseline_temp,
    input logic signed [tsjd_pkg::DEV_W-1:0]   o_deviation,
    input logic signed [tsjd_pkg::TEMP_W-1:0]  o_window_mean
);
    import tsjd_pkg::*;

    // a held word stays valid and keeps its event code and baseline
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_event_res) && $stable(o_baseline_temp))
        else $error("result word changed while stalled");

    // one sample at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    a_stab: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_res == EV_STAB |->
            o_locked && o_stable_now && o_beep == BEEP_SHORT &&
            o_deviation == '0 && o_baseline_temp == o_window_mean)
        else $error("stabilization word inconsistent");

    a_alert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_beep == BEEP_ALERT |-> o_event_res == EV_JUMP && o_locked)
        else $error("alert beep without locked jump");

    a_unlocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_locked |->
            o_event_res == EV_NONE && o_beep == BEEP_NONE && o_deviation == '0)
        else $error("unlocked word carries event or deviation");

endmodule

bind temperature_stability_jump_detector_top tsjd_checker u_tsjd_checker (.*);

### tb/tb_temperature_stability_jump_detector_top.sv
// Self-checking testbench for the temperature stability jump detector top level.
`timescale 1ns / 1ps

module tb_temperature_stability_jump_detector_top;
    import tsjd_pkg::*;

    localparam int HIST_DEPTH     = 32;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS    = 95;
    localparam int N_PHASES       = 12;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef struct packed {
        t_event                ev;
        t_beep                 bp;
        logic                  stable;
        logic                  locked;
        logic [TEMP_W-1:0]     base;
        logic [DEV_W-1:0]      dev;
        logic [TEMP_W-1:0]     mean;
        logic [TEMP_W-1:0]     spread;
    } t_reading;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] tol;
        logic [CFG_DATA_W-1:0] thr;
        logic [CFG_DATA_W-1:0] settle;
        logic [CFG_DATA_W-1:0] beep;
        logic [CFG_DATA_W-1:0] recent;
        logic [CFG_DATA_W-1:0] cooldown;
        logic [CFG_DATA_W-1:0] regain;
    } t_settings;

    typedef enum {SET_LOW, SET_HIGH, SET_ODD, SET_RANDOM} t_set_kind;
    typedef enum {PAT_STEADY, PAT_JUMP, PAT_DRIFT, PAT_WILD} t_pattern;

    // Tracks the detector state and queues the reading each accepted word must produce.
    class stability_tracker;
        logic [8:0]  stab_tol;
        logic [9:0]  jump_thr;
        logic [21:0] settle_ms;
        logic        beep_en;
        logic [19:0] recent_ms;
        logic [21:0] cooldown_ms;
        logic [21:0] regain_ms;
        int          ring_temp [HIST_DEPTH];
        logic [31:0] ring_time [HIST_DEPTH];
        int          wr_slot;
        int          fill;
        bit          is_locked;
        int          base_temp;
        bit          alert_held;
        logic [31:0] last_alert_ms;
        logic [31:0] stable_since_ms;
        t_reading    pending_readings[$];
        int          errors;
        int          n_checked;
        int          n_stab;
        int          n_jump;

        function new();
            stab_tol        = RST_STAB_TOL;
            jump_thr        = RST_JUMP_THR;
            settle_ms       = RST_SETTLE;
            beep_en         = 1'b1;
            recent_ms       = RST_RECENT;
            cooldown_ms     = RST_COOLDOWN;
            regain_ms       = RST_REGAIN;
            wr_slot         = 0;
            fill            = 0;
            is_locked       = 1'b0;
            base_temp       = -12700;
            alert_held      = 1'b0;
            last_alert_ms   = '0;
            stable_since_ms = '0;
            errors          = 0;
            n_checked       = 0;
            n_stab          = 0;
            n_jump          = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_STAB_TOL: stab_tol    = data[8:0];
                REG_JUMP_THR: jump_thr    = data[9:0];
                REG_SETTLE:   settle_ms   = data[21:0];
                REG_BEEP_EN:  beep_en     = data[0];
                REG_RECENT:   recent_ms   = data[19:0];
                REG_COOLDOWN: cooldown_ms = data[21:0];
                REG_REGAIN:   regain_ms   = data[21:0];
                default: ;
            endcase
        endfunction

        function void take_sample(int temp, logic [31:0] now);
            int          wmin, wmax, rmin, rmax;
            int          mean, spread, rspread, dev, absd, j;
            longint      sum, cnt;
            logic [31:0] age, oldest;
            bit          stable;
            t_reading    r;
            ring_temp[wr_slot] = temp;
            ring_time[wr_slot] = now;
            wr_slot = (wr_slot + 1) % HIST_DEPTH;
            if (fill < HIST_DEPTH) fill++;
            // current word has age 0, so it always seeds both windows
            wmin = temp; wmax = temp; rmin = temp; rmax = temp;
            sum = 0; cnt = 0; oldest = '0;
            for (j = 0; j < fill; j++) begin
                age = now - ring_time[j];
                if (age <= settle_ms) begin
                    if (ring_temp[j] < wmin) wmin = ring_temp[j];
                    if (ring_temp[j] > wmax) wmax = ring_temp[j];
                    sum += ring_temp[j];
                    cnt++;
                    if (age > oldest) oldest = age;
                end
                if (age <= recent_ms) begin
                    if (ring_temp[j] < rmin) rmin = ring_temp[j];
                    if (ring_temp[j] > rmax) rmax = ring_temp[j];
                end
            end
            mean    = int'(sum / cnt);
            spread  = wmax - wmin;
            rspread = rmax - rmin;
            stable  = (spread <= stab_tol) && (oldest >= (settle_ms >> 1));
            r.ev = EV_NONE;
            r.bp = BEEP_NONE;
            dev  = 0;
            if (!is_locked) begin
                if (stable) begin
                    is_locked       = 1'b1;
                    base_temp       = mean;
                    alert_held      = 1'b0;
                    stable_since_ms = now;
                    r.ev            = EV_STAB;
                    r.bp            = BEEP_SHORT;
                end
            end else begin
                dev  = temp - base_temp;
                absd = (dev < 0) ? -dev : dev;
                if (absd >= jump_thr) begin
                    if (rspread * 2 >= jump_thr) begin
                        if (!alert_held || (now - last_alert_ms) > cooldown_ms) begin
                            r.ev = EV_JUMP;
                            if (beep_en) r.bp = BEEP_ALERT;
                            alert_held    = 1'b1;
                            last_alert_ms = now;
                        end
                    end else begin
                        // slow drift: follow the window mean
                        base_temp  = mean;
                        alert_held = 1'b0;
                    end
                end else begin
                    alert_held = 1'b0;
                end
                if (!stable) begin
                    if ((now - stable_since_ms) > regain_ms) begin
                        base_temp       = mean;
                        stable_since_ms = now;
                    end
                end else begin
                    stable_since_ms = now;
                end
            end
            r.stable = stable;
            r.locked = is_locked;
            r.base   = base_temp[14:0];
            r.dev    = dev[15:0];
            r.mean   = mean[14:0];
            r.spread = spread[14:0];
            pending_readings.push_back(r);
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_reading(t_reading got);
            t_reading want;
            if (pending_readings.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result word, expected none, actual event %0d mean %0d",
                         $time, got.ev, $signed(got.mean));
                return;
            end
            want = pending_readings.pop_front();
            compare_field("event_res", want.ev, got.ev);
            compare_field("beep", want.bp, got.bp);
            compare_field("stable_now", want.stable, got.stable);
            compare_field("locked", want.locked, got.locked);
            compare_field("baseline_temp", $signed(want.base), $signed(got.base));
            compare_field("deviation", $signed(want.dev), $signed(got.dev));
            compare_field("window_mean", $signed(want.mean), $signed(got.mean));
            compare_field("window_spread", want.spread, got.spread);
            n_checked++;
            if (want.ev == EV_STAB) n_stab++;
            if (want.ev == EV_JUMP) n_jump++;
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_idx;
    logic [CFG_DATA_W-1:0]        i_cfg_data;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic signed [TEMP_W-1:0]     i_sample_temp;
    logic [TIME_W-1:0]            i_sample_time_ms;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic [1:0]                   o_event_res;
    logic [1:0]                   o_beep;
    logic                         o_stable_now;
    logic                         o_locked;
    logic signed [TEMP_W-1:0]     o_baseline_temp;
    logic signed [DEV_W-1:0]      o_deviation;
    logic signed [TEMP_W-1:0]     o_window_mean;
    logic [TEMP_W-1:0]            o_window_spread;

    stability_tracker sb;
    bit          tx_idle_on  = 1'b1;
    bit          rx_idle_on  = 1'b1;
    bit          rx_hold_req = 1'b0;
    logic [31:0] now_ms;
    int          n_settings  = 0;

    temperature_stability_jump_detector_top #(
        .HISTORY_DEPTH (HIST_DEPTH)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sample_temp    (i_sample_temp),
        .i_sample_time_ms (i_sample_time_ms),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_res      (o_event_res),
        .o_beep           (o_beep),
        .o_stable_now     (o_stable_now),
        .o_locked         (o_locked),
        .o_baseline_temp  (o_baseline_temp),
        .o_deviation      (o_deviation),
        .o_window_mean    (o_window_mean),
        .o_window_spread  (o_window_spread)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            sb.check_reading({o_event_res, o_beep, o_stable_now, o_locked, o_baseline_temp,
                              o_deviation, o_window_mean, o_window_spread});
        end
    end

    // output side: random stall, plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                hold_left   = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= rx_idle_on && ($urandom_range(99) < 38);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int clamp_temp(int v);
        if (v < -6500) return -6500;
        if (v > 13500) return 13500;
        return v;
    endfunction

    function automatic int rand_sym(int a);
        return int'($urandom_range(0, 2 * a)) - a;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(int temp, logic [31:0] ts);
        i_in_valid       <= 1'b1;
        i_sample_temp    <= temp[14:0];
        i_sample_time_ms <= ts;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.take_sample(temp, ts);
        @(negedge i_clk);
    endtask

    task automatic tx_gap();
        if (tx_idle_on && $urandom_range(99) < 38) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_readings.size() != 0) @(negedge i_clk);
    endtask

    // leaves the write enable high; the caller lowers it after the last write
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(t_settings s, bit poke_unused);
        cfg_write(REG_STAB_TOL, s.tol);
        cfg_write(REG_JUMP_THR, s.thr);
        cfg_write(REG_SETTLE, s.settle);
        cfg_write(REG_BEEP_EN, s.beep);
        cfg_write(REG_RECENT, s.recent);
        cfg_write(REG_COOLDOWN, s.cooldown);
        cfg_write(REG_REGAIN, s.regain);
        if (poke_unused) cfg_write(REG_NONE, 22'($urandom()));
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        n_settings++;
    endtask

    function automatic t_settings pick_settings(t_set_kind kind);
        t_settings s;
        case (kind)
            SET_LOW: begin
                s = {22'd1, 22'd5, 22'd60000, 22'd0, 22'd1000, 22'd0, 22'd0};
            end
            SET_HIGH: begin
                s = {22'd500, 22'd1000, 22'd3600000, 22'd1, 22'd600000, 22'd3600000,
                     22'd3600000};
            end
            SET_ODD: begin
                // out-of-range values, junk above the width of the tolerance, threshold, beep and recent registers
                s.tol         = 22'($urandom());
                s.tol[8:0]    = $urandom_range(1) ? 9'd0 : 9'($urandom_range(501, 511));
                s.thr         = 22'($urandom());
                s.thr[9:0]    = $urandom_range(1) ? 10'($urandom_range(0, 4))
                                                  : 10'($urandom_range(1001, 1023));
                s.settle      = $urandom_range(1) ? 22'($urandom_range(0, 59999))
                                                  : 22'($urandom_range(3600001, 4194303));
                s.beep        = 22'($urandom());
                s.recent      = 22'($urandom());
                s.recent[19:0] = $urandom_range(1) ? 20'($urandom_range(0, 999))
                                                   : 20'($urandom_range(600001, 1048575));
                s.cooldown    = 22'($urandom_range(3600001, 4194303));
                s.regain      = 22'($urandom_range(3600001, 4194303));
            end
            default: begin
                s.tol      = $urandom_range(1, 500);
                s.thr      = $urandom_range(5, 1000);
                s.settle   = $urandom_range(60000, 3600000);
                s.beep     = $urandom_range(1);
                s.recent   = $urandom_range(1000, 600000);
                s.cooldown = $urandom_range(0, 3600000);
                s.regain   = $urandom_range(0, 3600000);
            end
        endcase
        return s;
    endfunction

    // settling runs, jumps, slow drift and wild stretches, with some noise words
    task automatic run_phase(int n_items, int hold_at, bit near_wrap);
        t_pattern pat;
        int       left, level, temp, stride, dir, tol_i, thr_i, k, r;
        logic [31:0] ts;
        tol_i  = sb.stab_tol;
        thr_i  = sb.jump_thr;
        stride = (sb.settle_ms / 2) / $urandom_range(10, 28) + $urandom_range(1, 50);
        if (near_wrap) now_ms = 32'hFFFF_FFFF - 32'(stride * 20);
        level  = int'($urandom_range(19000)) - 6000;
        pat    = PAT_STEADY;
        left   = $urandom_range(8, 40);
        dir    = 1;
        for (k = 0; k < n_items; k++) begin
            if (k == hold_at) rx_hold_req = 1'b1;
            if ($urandom_range(99) < 12) begin
                temp = int'($urandom_range(20000)) - 6500;
                case ($urandom_range(2))
                    0:       ts = $urandom();
                    1:       ts = now_ms - $urandom_range(0, 4 * stride);
                    default: ts = now_ms + $urandom_range(1, 8 * stride);
                endcase
            end else begin
                case (pat)
                    PAT_STEADY: temp = level + rand_sym(tol_i / 2);
                    PAT_JUMP: begin
                        level = clamp_temp(level + dir * (thr_i + $urandom_range(0, 2 * thr_i)));
                        temp  = level;
                    end
                    PAT_DRIFT: begin
                        level = clamp_temp(level + dir * $urandom_range(1, thr_i / 3 + 1));
                        temp  = level;
                    end
                    default: temp = level + rand_sym(tol_i * 2 + 50);
                endcase
                now_ms += stride + $urandom_range(0, stride / 4);
                ts = now_ms;
                left--;
                if (left <= 0) begin
                    r   = $urandom_range(99);
                    dir = $urandom_range(1) ? 1 : -1;
                    if (r < 45) begin
                        pat = PAT_STEADY; left = $urandom_range(8, 40);
                    end else if (r < 65) begin
                        pat = PAT_JUMP; left = 1;
                    end else if (r < 80) begin
                        pat = PAT_DRIFT; left = $urandom_range(4, 15);
                    end else begin
                        pat = PAT_WILD; left = $urandom_range(5, 25);
                    end
                end
            end
            send_word(clamp_temp(temp), ts);
            tx_gap();
        end
    endtask

    task automatic run_directed();
        int          k;
        logic [31:0] t0;
        t0 = 32'd100000;
        // settles at the sixteenth word with the reset window of ten minutes
        for (k = 0; k < 16; k++) begin
            send_word(2500 + int'($urandom_range(0, 4)), t0 + k * 20000);
            tx_gap();
        end
        send_word(2600, t0 + 16 * 20000);   // sharp jump, alert
        send_word(2610, t0 + 17 * 20000);   // inside cooldown
        tx_gap();
        send_word(2700, t0 + 20 * 20000);   // lone deviation, baseline follows
        send_word(13500, t0 + 21 * 20000);
        send_word(-6500, t0 + 22 * 20000);
        tx_gap();
        send_word(0, t0 + 23 * 20000);
        send_word(2500, 32'hFFFF_FFFF);
        send_word(2500, 32'd0);             // timestamp wraps
        send_word(2500, 32'd50);
        send_word(2500, t0);                // older stamp, looks like the future
    endtask

    initial begin
        t_set_kind kind;
        int        p;
        sb               = new();
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_sample_temp    = '0;
        i_sample_time_ms = '0;
        now_ms           = 32'd1000000;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        drain();
        now_ms = 32'd1000000;

        for (p = 0; p < N_PHASES; p++) begin
            if (p == 0)
                kind = SET_LOW;
            else if (p == 1)
                kind = SET_HIGH;
            else if (p == 2 || p == 7)
                kind = SET_ODD;
            else
                kind = SET_RANDOM;
            apply_settings(pick_settings(kind), kind == SET_ODD);
            tx_idle_on = (p != 6);
            rx_idle_on = (p != 6);
            run_phase(PHASE_ITEMS, (p == 4 || p == 9) ? 30 : -1, p == 5);
            drain();
        end

        repeat (100) @(negedge i_clk);
        $display("Checked %0d result words over %0d register settings plus the reset setting",
                 sb.n_checked, n_settings);
        $display("Saw %0d stabilizations and %0d jump alerts", sb.n_stab, sb.n_jump);
        if (sb.errors == 0 && sb.pending_readings.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### temperature_stability_jump_detector_top.f
rtl/tsjd_pkg.sv
rtl/temperature_stability_jump_detector_top.sv
rtl/tsjd_checker.sv
tb/tb_temperature_stability_jump_detector_top.sv
